// ----- sv/mrrc_pkg.sv -----
// ----------------------------------------------------------------------------
// Memory region range check package
// Shared types, sizes and codes for the region table and its query logic.
// ----------------------------------------------------------------------------
package mrrc_pkg;

    // Table size and derived widths
    localparam int MAX_REGIONS = 32;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    // Operation codes
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_WRAP = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;
    localparam logic [1:0] STATUS_ZERO = 2'd3;

    // Request transaction
    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] range_start;
        logic [63:0] range_length;
        logic [31:0] region_kind;
    } req_item_t;

    // Response transaction
    typedef struct packed {
        logic       covered;
        logic [1:0] status;
        logic [5:0] entries_used;
    } rsp_item_t;

    // One stored region, with its end precomputed at 65 bits
    typedef struct packed {
        logic [63:0] start_addr;
        logic [64:0] end_addr;
        logic [31:0] kind;
    } tbl_entry_t;

    // Sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_SCAN,
        SEQ_RESP
    } seq_state_t;

endpackage

// ----- sv/mrrc_cover_cmp.sv -----
// ----------------------------------------------------------------------------
// Region cover comparator
// Decides whether one stored region is free and covers the queried range.
// ----------------------------------------------------------------------------
module mrrc_cover_cmp (
    input  mrrc_pkg::tbl_entry_t entry,
    input  logic [63:0]          q_start,
    input  logic [64:0]          q_end,
    input  logic [31:0]          free_type,
    output logic                 hit
);

    // The region must start no later and end no earlier than the range
    assign hit = (entry.start_addr <= q_start) &&
                 (entry.end_addr >= q_end) &&
                 (entry.kind == free_type);

endmodule

// ----- sv/memory_region_range_check.sv -----
// Clear, add, unused codes and wrapping queries go from acceptance through the execute state to the response register.
// A non-wrapping query also passes through the table walk, even on an empty table; the walk
// reads one entry per cycle through a single memory port and stops early on a hit.
// One transaction at a time; the next request is taken the cycle after the response register is
// loaded, and that load waits while the output is stalled.
// Reset clears the region count and sets free_type to 1; table contents are kept.
// ----------------------------------------------------------------------------
// Memory region range check
// Region table with clear, add and containment query, walked by a sequencer
// that shares one 65-bit adder and one comparator.
// ----------------------------------------------------------------------------
module memory_region_range_check (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  mrrc_pkg::req_item_t  req_data,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output mrrc_pkg::rsp_item_t  rsp_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);

    localparam int CNT_W = mrrc_pkg::CNT_W;
    localparam int IDX_W = mrrc_pkg::IDX_W;

    // Region table memory
    mrrc_pkg::tbl_entry_t table_mem [mrrc_pkg::MAX_REGIONS];

    mrrc_pkg::seq_state_t state_reg, state_next;
    mrrc_pkg::req_item_t  req_reg, req_next;
    mrrc_pkg::rsp_item_t  res_reg, res_next;
    mrrc_pkg::rsp_item_t  rsp_data_reg, rsp_data_next;
    mrrc_pkg::tbl_entry_t rd_entry_reg;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [64:0]          qend_reg, qend_next;
    logic [31:0]          free_type_reg;

    logic                 req_accept;
    logic                 rsp_load;
    logic                 mem_we;
    logic                 rd_issue;
    logic [64:0]          sum;
    logic                 q_wrap;
    logic                 hit;
    logic                 cmp_hit;
    logic                 scan_done;

    // Handshake outputs
    assign req_stall  = (state_reg != mrrc_pkg::SEQ_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;
    assign cfg_ready  = 1'b1;

    // Shared 65-bit adder: region end on add, range end on query
    assign sum    = {1'b0, req_reg.range_start} + {1'b0, req_reg.range_length};
    assign q_wrap = sum[64] && (sum[63:0] != 64'd0);

    // Shared comparator on the registered table entry
    mrrc_cover_cmp u_cmp (
        .entry     (rd_entry_reg),
        .q_start   (req_reg.range_start),
        .q_end     (qend_reg),
        .free_type (free_type_reg),
        .hit       (cmp_hit)
    );

    assign hit       = rd_valid_reg && cmp_hit;
    assign rd_issue  = (state_reg == mrrc_pkg::SEQ_SCAN) && (scan_cnt_reg < count_reg);
    assign scan_done = hit || (!rd_issue && !rd_valid_reg);
    assign rsp_load  = (state_reg == mrrc_pkg::SEQ_RESP) && (!rsp_valid_reg || !rsp_stall);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrrc_pkg::SEQ_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = mrrc_pkg::SEQ_EXEC;
                end
            end
            mrrc_pkg::SEQ_EXEC:
            begin
                if (req_reg.func == mrrc_pkg::FUNC_QUERY && !q_wrap)
                begin
                    state_next = mrrc_pkg::SEQ_SCAN;
                end
                else
                begin
                    state_next = mrrc_pkg::SEQ_RESP;
                end
            end
            mrrc_pkg::SEQ_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = mrrc_pkg::SEQ_RESP;
                end
            end
            mrrc_pkg::SEQ_RESP:
            begin
                if (rsp_load)
                begin
                    state_next = mrrc_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = mrrc_pkg::SEQ_IDLE;
            end
        endcase
    end

    // Datapath and output values
    always_comb
    begin
        req_next       = req_reg;
        res_next       = res_reg;
        count_next     = count_reg;
        scan_cnt_next  = scan_cnt_reg;
        qend_next      = qend_reg;
        rd_valid_next  = 1'b0;
        mem_we         = 1'b0;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;

        // The output register empties when its transaction is taken
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            mrrc_pkg::SEQ_IDLE:
            begin
                if (req_accept)
                begin
                    req_next = req_data;
                end
            end
            mrrc_pkg::SEQ_EXEC:
            begin
                res_next.covered = 1'b0;
                res_next.status  = mrrc_pkg::STATUS_OK;
                case (req_reg.func)
                    mrrc_pkg::FUNC_CLEAR:
                    begin
                        count_next = '0;
                    end
                    mrrc_pkg::FUNC_ADD:
                    begin
                        if (req_reg.range_length == 64'd0)
                        begin
                            res_next.status = mrrc_pkg::STATUS_ZERO;
                        end
                        else if (count_reg >= CNT_W'(mrrc_pkg::MAX_REGIONS))
                        begin
                            res_next.status = mrrc_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    mrrc_pkg::FUNC_QUERY:
                    begin
                        qend_next     = sum;
                        scan_cnt_next = '0;
                        if (q_wrap)
                        begin
                            res_next.status = mrrc_pkg::STATUS_WRAP;
                        end
                    end
                    default:
                    begin
                        res_next.status = mrrc_pkg::STATUS_OK;
                    end
                endcase
                res_next.entries_used = 6'(count_next);
            end
            mrrc_pkg::SEQ_SCAN:
            begin
                // One table read issued per cycle; the compare acts on the registered entry in the next cycle
                if (rd_issue)
                begin
                    scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                end
                rd_valid_next    = rd_issue && !hit;
                res_next.covered = hit;
            end
            mrrc_pkg::SEQ_RESP:
            begin
                if (rsp_load)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                end
            end
            default:
            begin
                rd_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrrc_pkg::SEQ_IDLE;
            count_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            free_type_reg <= 32'd1;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                free_type_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        res_reg      <= res_next;
        scan_cnt_reg <= scan_cnt_next;
        qend_reg     <= qend_next;
        rsp_data_reg <= rsp_data_next;
    end

    // Table write on add, registered read during the walk
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[count_reg[IDX_W-1:0]] <= '{start_addr: req_reg.range_start,
                                                 end_addr:   sum,
                                                 kind:       req_reg.region_kind};
        end
        if (rd_issue)
        begin
            rd_entry_reg <= table_mem[scan_cnt_reg[IDX_W-1:0]];
        end
    end

`ifndef SYNTHESIS
    // The stored count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(mrrc_pkg::MAX_REGIONS))
        else $error("region count exceeds table size");

    // A covered answer always carries an ok status
    a_covered_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.covered |-> rsp_data.status == mrrc_pkg::STATUS_OK)
        else $error("covered response with non-ok status");

    // After a request is taken the block holds off the next one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while a transaction is in progress");

    // The table walk never reads beyond the stored regions
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mrrc_pkg::SEQ_SCAN |-> scan_cnt_reg <= count_reg)
        else $error("table walk beyond stored regions");
`endif

endmodule

// ----- tb/sv/region_table_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Region table response checker
// Watches the request, response and free-type write channels of the memory
// region range check, keeps its own copy of the region table, works out the
// answer to every accepted request and compares each accepted response with
// the oldest answer still waiting.
// ----------------------------------------------------------------------------
module region_table_checker
    import mrrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_item_t   req_data,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_item_t   rsp_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        end_of_run,
    output int          fail_count,
    output int          outstanding,
    output int          checked_count
);

    // One past the highest byte address; a range may end here but not beyond.
    localparam logic [64:0] ADDR_SPACE_END = 65'h1_0000_0000_0000_0000;
    localparam int          PRINT_CAP      = 30;

    // Own copy of the region table and the free-type register.
    logic [63:0] table_starts  [MAX_REGIONS];
    logic [63:0] table_lengths [MAX_REGIONS];
    logic [31:0] table_kinds   [MAX_REGIONS];
    int          table_count;
    logic [31:0] table_free_type;

    // Answers predicted for accepted requests, oldest first.
    rsp_item_t   pending_answers[$];
    rsp_item_t   oldest_answer;
    rsp_item_t   new_answer;
    bit          leftovers_reported;

    // Prints one line for a failure and counts it.
    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    // Applies one request to the table copy and works out its response.
    task automatic predict_region_answer(input req_item_t req, output rsp_item_t ans);
        logic [64:0] query_end;
        logic [64:0] region_end;
        ans.covered = 1'b0;
        ans.status  = STATUS_OK;
        case (req.func)
            FUNC_CLEAR: table_count = 0;
            FUNC_ADD:
            begin
                if (req.range_length == 64'd0)
                    ans.status = STATUS_ZERO;
                else if (table_count >= MAX_REGIONS)
                    ans.status = STATUS_FULL;
                else
                begin
                    table_starts[table_count]  = req.range_start;
                    table_lengths[table_count] = req.range_length;
                    table_kinds[table_count]   = req.region_kind;
                    table_count++;
                end
            end
            FUNC_QUERY:
            begin
                // All ends are taken at 65 bits so that no sum wraps.
                query_end = {1'b0, req.range_start} + {1'b0, req.range_length};
                if (query_end > ADDR_SPACE_END)
                    ans.status = STATUS_WRAP;
                else
                begin
                    for (int i = 0; i < table_count; i++)
                    begin
                        region_end = {1'b0, table_starts[i]} + {1'b0, table_lengths[i]};
                        if (table_starts[i] <= req.range_start && region_end >= query_end &&
                            table_kinds[i] == table_free_type)
                            ans.covered = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        ans.entries_used = table_count[5:0];
    endtask

    // Channel monitor: register write, response check, then request prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_count        = 0;
            table_free_type    = 32'd1;
            fail_count         = 0;
            checked_count      = 0;
            leftovers_reported = 1'b0;
            pending_answers.delete();
            outstanding       <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                table_free_type = cfg_data;

            // Compare every accepted response transaction with the oldest answer.
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_answers.size() == 0)
                    report_mismatch($sformatf(
                        "response with nothing expected: covered %0d status %0d entries %0d",
                        rsp_data.covered, rsp_data.status, rsp_data.entries_used));
                else
                begin
                    oldest_answer = pending_answers.pop_front();
                    checked_count++;
                    if (rsp_data.covered !== oldest_answer.covered ||
                        rsp_data.status !== oldest_answer.status ||
                        rsp_data.entries_used !== oldest_answer.entries_used)
                        report_mismatch($sformatf(
                            "covered %0d/%0d status %0d/%0d entries %0d/%0d (got/expected)",
                            rsp_data.covered, oldest_answer.covered,
                            rsp_data.status, oldest_answer.status,
                            rsp_data.entries_used, oldest_answer.entries_used));
                end
            end

            if (req_valid && !req_stall)
            begin
                predict_region_answer(req_data, new_answer);
                pending_answers.push_back(new_answer);
            end

            // Answers still waiting once the run is over are failures.
            if (end_of_run && !leftovers_reported)
            begin
                leftovers_reported = 1'b1;
                if (pending_answers.size() != 0)
                    report_mismatch($sformatf("%0d expected responses never arrived",
                                              pending_answers.size()));
            end

            outstanding <= pending_answers.size();
        end
    end

endmodule

// ----- tb/sv/memory_region_range_check_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Memory region range check testbench
// Drives clear, add, query and unused-code requests into the region table,
// first as a directed set of edge cases and then as random fill-and-query
// episodes, under several free-type settings and flow-control mixes. The
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module memory_region_range_check_test;
    import mrrc_pkg::*;

    localparam logic [1:0] FUNC_NOP      = 2'd3;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         RANDOM_ITEMS  = 800;
    localparam int         PHASES        = 5;
    localparam int         SETTLE_CYCLES = MAX_REGIONS + 8;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        req_valid  = 1'b0;
    logic        req_stall;
    req_item_t   req_data   = '0;
    logic        rsp_valid;
    logic        rsp_stall  = 1'b0;
    rsp_item_t   rsp_data;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data   = '0;
    logic        end_of_run = 1'b0;

    int          fail_count;
    int          outstanding;
    int          checked_count;
    int          items_sent  = 0;
    int          cycle_count = 0;
    int          idle_pct    = 0;
    int          stall_pct   = 0;
    logic [31:0] cur_free_type = 32'd1;

    // Regions the block should hold, kept only to aim queries at them.
    logic [63:0] placed_start [MAX_REGIONS];
    logic [63:0] placed_len   [MAX_REGIONS];
    int          placed_count = 0;

    memory_region_range_check dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    region_table_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_data      (req_data),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .rsp_data      (rsp_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .end_of_run    (end_of_run),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure.
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < stall_pct);

    // Watchdog: ends a run that has hung.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles", cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic req_item_t make_request(input logic [1:0] func, input logic [63:0] start,
                                               input logic [63:0] length, input logic [31:0] kind);
        req_item_t item;
        item.func         = func;
        item.range_start  = start;
        item.range_length = length;
        item.region_kind  = kind;
        return item;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Addresses spread over small, 2^32-aligned, top-of-space, zero or all-ones, and fully random values.
    function automatic logic [63:0] rand_addr();
        case ($urandom_range(4))
            0:       return 64'($urandom_range(65535));
            1:       return {$urandom, 32'h0};
            2:       return ALL_ONES - 64'($urandom_range(65535));
            3:       return ($urandom_range(1) == 0) ? 64'd0 : ALL_ONES;
            default: return rand64();
        endcase
    endfunction

    // Non-zero lengths from one byte up to one byte short of the whole address space.
    function automatic logic [63:0] rand_len();
        logic [63:0] len;
        case ($urandom_range(3))
            0:       len = 64'($urandom_range(1, 4096));
            1:       len = {32'h0, $urandom};
            2:       len = ALL_ONES - 64'($urandom_range(15));
            default: len = rand64();
        endcase
        return (len == 64'd0) ? 64'd1 : len;
    endfunction

    // Mostly the free type, sometimes one bit off it, sometimes anything.
    function automatic logic [31:0] random_kind();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return cur_free_type;
            5, 6:          return cur_free_type ^ (32'd1 << $urandom_range(31));
            default:       return $urandom;
        endcase
    endfunction

    // Queries aimed at a held region (exact, inside, one past its end,
    // one before its start) or anywhere at all.
    function automatic req_item_t random_query();
        req_item_t   q;
        int          j;
        logic [63:0] s;
        logic [63:0] l;
        logic [63:0] off;
        logic [63:0] room;
        q = make_request(FUNC_QUERY, rand_addr(), rand_len(), $urandom);
        if (placed_count > 0 && $urandom_range(9) < 7)
        begin
            j    = $urandom_range(placed_count - 1);
            s    = placed_start[j];
            l    = placed_len[j];
            off  = ($urandom_range(1) == 0) ? 64'($urandom_range(255)) % l : rand64() % l;
            room = l - off;
            case ($urandom_range(3))
                0:
                begin
                    q.range_start  = s;
                    q.range_length = l;
                end
                1:
                begin
                    q.range_start  = s + off;
                    q.range_length = (room == ALL_ONES) ? rand64() : rand64() % (room + 64'd1);
                end
                2:
                begin
                    q.range_start  = s + off;
                    q.range_length = room + 64'd1;
                end
                default:
                begin
                    q.range_start  = s - 64'd1;
                    q.range_length = l;
                end
            endcase
        end
        else if ($urandom_range(4) == 0)
            q.range_length = 64'd0;
        return q;
    endfunction

    // Offers one request transaction, waits for it to be taken, then maybe idles.
    task automatic send_req(input req_item_t item);
        req_data  <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
        if (item.func == FUNC_CLEAR)
            placed_count = 0;
        else if (item.func == FUNC_ADD && item.range_length != 0 && placed_count < MAX_REGIONS)
        begin
            placed_start[placed_count] = item.range_start;
            placed_len[placed_count]   = item.range_length;
            placed_count++;
        end
        if ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    // Waits until every expected response has come back and the block is quiet.
    task automatic drain_and_settle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_free_type(input logic [31:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_free_type = value;
    endtask

    // One episode: clear, then a run of adds mixed with queries and noise.
    // Some episodes add well past the table size to reach the full case.
    task automatic run_episode();
        int n_adds;
        int pick;
        send_req(make_request(FUNC_CLEAR, rand64(), rand64(), $urandom));
        n_adds = ($urandom_range(3) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
        repeat (n_adds * 2 + 2)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                send_req(make_request(FUNC_ADD, rand_addr(), rand_len(), random_kind()));
            else if (pick < 90)
                send_req(random_query());
            else if (pick < 95)
                send_req(make_request(FUNC_ADD, rand_addr(), 64'd0, random_kind()));
            else
                send_req(make_request(FUNC_NOP, rand64(), rand64(), $urandom));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        logic [31:0] free_settings [PHASES];
        int          target;
        free_settings = '{32'd1, 32'd0, 32'hFFFF_FFFF, $urandom, 32'd1};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed edge cases with the reset free type.
        send_req(make_request(FUNC_QUERY, 64'd0, 64'd0, 32'd0));
        send_req(make_request(FUNC_ADD, 64'h5000, 64'd0, 32'd1));
        send_req(make_request(FUNC_ADD, 64'h1000, 64'h1000, 32'd1));
        send_req(make_request(FUNC_ADD, 64'h1000, 64'h1000, 32'd2));
        send_req(make_request(FUNC_QUERY, 64'h1000, 64'h1000, 32'hFFFF_FFFF));
        send_req(make_request(FUNC_QUERY, 64'h1800, 64'd0, 32'd0));
        send_req(make_request(FUNC_QUERY, 64'h2000, 64'd0, 32'd0));
        send_req(make_request(FUNC_QUERY, 64'h1000, 64'h1001, 32'd0));
        send_req(make_request(FUNC_QUERY, 64'h0FFF, 64'h10, 32'd0));
        // A query running past the top of the address space.
        send_req(make_request(FUNC_QUERY, ALL_ONES, 64'd2, 32'd0));
        // A query ending exactly at the top of the address space.
        send_req(make_request(FUNC_QUERY, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 32'd0));
        send_req(make_request(FUNC_ADD, ALL_ONES, ALL_ONES, 32'd1));
        send_req(make_request(FUNC_ADD, 64'd0, ALL_ONES, 32'hFFFF_FFFF));
        send_req(make_request(FUNC_QUERY, ALL_ONES, 64'd1, 32'd0));
        send_req(make_request(FUNC_QUERY, ALL_ONES, ALL_ONES, 32'd0));
        send_req(make_request(FUNC_QUERY, 64'd0, ALL_ONES, 32'd0));
        send_req(make_request(FUNC_QUERY, ALL_ONES, 64'd0, 32'd0));
        send_req(make_request(FUNC_NOP, 64'h1234, 64'h10, 32'd1));
        send_req(make_request(FUNC_NOP, ALL_ONES, ALL_ONES, 32'hFFFF_FFFF));
        send_req(make_request(FUNC_CLEAR, ALL_ONES, ALL_ONES, 32'hFFFF_FFFF));
        send_req(make_request(FUNC_QUERY, 64'h1000, 64'h10, 32'd0));

        // Random episodes, one free-type setting and flow mix per phase.
        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain_and_settle();
                write_free_type(free_settings[p]);
            end
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 50; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            target = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < target)
                run_episode();
        end

        drain_and_settle();
        end_of_run <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Sent %0d requests (clear, add, query, unused code) under %0d free-type settings",
                 items_sent, PHASES);
        $display("and four flow-control mixes; %0d responses checked in %0d cycles.",
                 checked_count, cycle_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/mrrc_pkg.sv
sv/mrrc_cover_cmp.sv
sv/memory_region_range_check.sv
tb/sv/region_table_checker.sv
tb/sv/memory_region_range_check_test.sv
